/* rtl/inflight_index_window_macros.svh */
// Assertion helpers for the index window RTL.
`ifndef INFLIGHT_INDEX_WINDOW_MACROS_SVH
`define INFLIGHT_INDEX_WINDOW_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IIW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequence must hold in the cycle after the antecedent.
`define IIW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iiw_pkg.sv */
package iiw_pkg;

  // Built ring capacity and derived widths.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned IDX_W    = 63;
  localparam int unsigned SIZE_W   = 9;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ADD        = 2'd0,
    REQ_FREE_LE    = 2'd1,
    REQ_FREE_FIRST = 2'd2
  } req_type_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] log_index;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic             add_accepted;
    logic [CNT_W-1:0] freed_count;
    logic [CNT_W-1:0] occupancy;
    logic             window_full;
  } rsp_t;

endpackage

/* rtl/iiw_ram.sv */
module iiw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/inflight_index_window.sv */
// Window of outstanding log indexes kept in a single-port-write, registered-read ring RAM.
// A request is taken when start is high and busy and cfg_we_i are low; its result appears
// on rsp_o for exactly one cycle with result_valid_o high, on the cycle after the request
// finishes, and the receiver cannot stall it. Add, free-oldest and unused request codes
// finish in the accept cycle, so those can arrive every cycle. A free-up-to request holds
// busy while it reads ring entries one at a time (every entry it frees, plus the first
// larger one if the scan stops there), since each is a registered RAM read; on an empty
// window it finishes at once. A configuration write sets the window size and, in the idle
// state, empties the window, abandoning the stored indexes. No clearing pass runs after reset.
`include "inflight_index_window_macros.svh"

module inflight_index_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  iiw_pkg::req_t               req_i,
  input  logic                        cfg_we_i,
  input  logic [iiw_pkg::SIZE_W-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output iiw_pkg::rsp_t               rsp_o
);

  import iiw_pkg::*;

  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   size_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SLOT_W-1:0]   oldest_q, oldest_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [CNT_W-1:0]    freed_q, freed_d;
  logic [IDX_W-1:0]    bound_q, bound_d;
  rsp_t                rsp_q, rsp_d;
  logic                valid_q, valid_d;

  logic [SIZE_W-1:0]   eff_size;
  logic [SLOT_W-1:0]   append_slot;
  logic [SLOT_W:0]     append_sum;
  logic [SLOT_W-1:0]   rd_addr;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_rdata;
  logic                scan_pass;
  logic [CNT_W-1:0]    cnt_new;
  logic [CNT_W-1:0]    freed_new;
  logic [SLOT_W-1:0]   slot_new;

  // Next slot around the ring of eff_size entries.
  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] slot,
                                                  logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] inc;
    inc = {{(SIZE_W + 1 - SLOT_W){1'b0}}, slot} + (SIZE_W + 1)'(1);
    if (inc >= {1'b0, size}) begin
      return '0;
    end
    return inc[SLOT_W-1:0];
  endfunction

  // Effective size: the register clamped to 1..CAPACITY.
  always_comb begin
    if (size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_q > SIZE_W'(CAPACITY)) begin
      eff_size = SIZE_W'(CAPACITY);
    end else begin
      eff_size = size_q;
    end
  end

  // Append position: oldest plus count stays below twice the size.
  always_comb begin
    logic [SIZE_W:0] raw;
    raw = {{(SIZE_W + 1 - SLOT_W){1'b0}}, oldest_q} + {1'b0, count_q};
    if (raw >= {1'b0, eff_size}) begin
      raw = raw - {1'b0, eff_size};
    end
    append_sum  = raw[SLOT_W:0];
    append_slot = append_sum[SLOT_W-1:0];
  end

  // Ring storage of the indexes.
  iiw_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (append_slot),
    .wdata_i (req_i.log_index),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Scan step: does the entry just read fall at or below the bound.
  assign scan_pass = (ram_rdata <= bound_q);

  // Next state, ring update and result.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    oldest_d  = oldest_q;
    slot_d    = slot_q;
    freed_d   = freed_q;
    bound_d   = bound_q;
    rsp_d     = rsp_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    rd_addr   = oldest_q;
    cnt_new   = count_q;
    freed_new = freed_q;
    slot_new  = slot_q;

    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          count_d  = '0;
          oldest_d = '0;
        end else if (start) begin
          rsp_d.add_accepted = 1'b0;
          rsp_d.freed_count  = '0;
          rsp_d.occupancy    = count_q;
          rsp_d.window_full  = (count_q == eff_size);
          valid_d            = 1'b1;
          case (req_i.req_type)
            REQ_ADD: begin
              if (count_q < eff_size) begin
                ram_we             = 1'b1;
                cnt_new            = count_q + CNT_W'(1);
                count_d            = cnt_new;
                rsp_d.add_accepted = 1'b1;
                rsp_d.occupancy    = cnt_new;
                rsp_d.window_full  = (cnt_new == eff_size);
              end
            end
            REQ_FREE_LE: begin
              if (count_q != '0) begin
                valid_d = 1'b0;
                state_d = ST_SCAN;
                freed_d = '0;
                slot_d  = oldest_q;
                bound_d = req_i.log_index;
              end
            end
            REQ_FREE_FIRST: begin
              if (count_q != '0) begin
                cnt_new           = count_q - CNT_W'(1);
                count_d           = cnt_new;
                oldest_d          = (cnt_new == '0) ? '0 : next_slot(oldest_q, eff_size);
                rsp_d.freed_count = CNT_W'(1);
                rsp_d.occupancy   = cnt_new;
                rsp_d.window_full = (cnt_new == eff_size);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_pass) begin
          freed_new = freed_q + CNT_W'(1);
          slot_new  = next_slot(slot_q, eff_size);
        end
        freed_d = freed_new;
        slot_d  = slot_new;
        rd_addr = slot_new;
        if (!scan_pass || freed_new == count_q) begin
          cnt_new            = count_q - freed_new;
          count_d            = cnt_new;
          oldest_d           = (cnt_new == '0) ? '0 : slot_new;
          rsp_d.add_accepted = 1'b0;
          rsp_d.freed_count  = freed_new;
          rsp_d.occupancy    = cnt_new;
          rsp_d.window_full  = (cnt_new == eff_size);
          valid_d            = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      size_q   <= SIZE_W'(256);
      count_q  <= '0;
      oldest_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      valid_q  <= valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // Scan and result payload.
  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    freed_q <= freed_d;
    bound_q <= bound_d;
    rsp_q   <= rsp_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // The window never holds more entries than its size.
  `IIW_ASSERT(a_count_in_size, count_q <= eff_size, "occupancy above window size")
  // An empty window has its oldest pointer at slot zero.
  `IIW_ASSERT(a_empty_at_zero, count_q != '0 || oldest_q == '0, "empty window off slot zero")
  // Every accepted beat either yields a result next cycle or starts a scan.
  `IIW_ASSERT_NEXT(a_beat_taken, start && !busy && !cfg_we_i, result_valid_o || busy, "beat lost")
  // A scan never frees more entries than are in flight.
  `IIW_ASSERT(a_scan_bound, state_q != ST_SCAN || freed_q < count_q, "scan ran past occupancy")

endmodule

/* bench/inflight_index_window_checker.sv */
// Watches the request, configuration and result channels of the index window.
// Keeps its own copy of the ring, predicts one result beat per accepted request
// and compares every result beat with the oldest prediction still waiting.
module inflight_index_window_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  iiw_pkg::req_t              req_i,
  input  logic                       cfg_we_i,
  input  logic [iiw_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                       rsp_valid_i,
  input  iiw_pkg::rsp_t              rsp_i,
  output int                         pending_o,
  output int                         mismatches_o,
  output int                         checked_o,
  output int                         refused_o,
  output int                         full_seen_o
);

  import iiw_pkg::*;

  // Shadow of the ring and its pointers.
  logic [IDX_W-1:0]  shadow_ring [CAPACITY];
  int unsigned       head_slot;
  int unsigned       live_count;
  logic [SIZE_W-1:0] size_reg;

  // Predicted result beats, oldest first.
  rsp_t              rsp_pending_q [$];
  rsp_t              want;
  int                mismatch_total;
  int                checked_total;
  int                refused_total;
  int                full_total;

  // Ring slots in use: zero acts as one, anything above the capacity as the capacity.
  function automatic int unsigned slots_in_use();
    if (size_reg == '0) return 1;
    if (size_reg > CAPACITY) return CAPACITY;
    return size_reg;
  endfunction

  // Applies one request to the shadow ring and returns the result it must give.
  function automatic rsp_t window_apply(req_t rq);
    rsp_t        res;
    int unsigned sz;
    int unsigned slot;
    int unsigned freed;
    sz = slots_in_use();
    freed = 0;
    res = '0;
    if (live_count > sz) live_count = sz;
    if (head_slot >= sz) head_slot = head_slot % sz;
    case (rq.req_type)
      REQ_ADD: begin
        if (live_count < sz) begin
          slot = head_slot + live_count;
          if (slot >= sz) slot -= sz;
          shadow_ring[slot] = rq.log_index;
          live_count++;
          res.add_accepted = 1'b1;
        end
      end
      REQ_FREE_LE: begin
        // Release from the oldest entry until one is above the bound.
        slot = head_slot;
        while (freed < live_count && shadow_ring[slot] <= rq.log_index) begin
          freed++;
          slot = (slot + 1 >= sz) ? slot + 1 - sz : slot + 1;
        end
        live_count -= freed;
        head_slot = slot;
      end
      REQ_FREE_FIRST: begin
        if (live_count > 0) begin
          freed = 1;
          live_count--;
          head_slot = (head_slot + 1 >= sz) ? head_slot + 1 - sz : head_slot + 1;
        end
      end
      default: ;
    endcase
    if (live_count == 0) head_slot = 0;
    res.freed_count = freed[CNT_W-1:0];
    res.occupancy   = live_count[CNT_W-1:0];
    res.window_full = (live_count == sz);
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    mismatch_total++;
  endtask

  // Compare result beats first: a beat seen at an edge always belongs to an
  // earlier request than one accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_slot      = 0;
      live_count     = 0;
      size_reg       = SIZE_W'(CAPACITY);
      mismatch_total = 0;
      checked_total  = 0;
      refused_total  = 0;
      full_total     = 0;
      rsp_pending_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
      refused_o    <= 0;
      full_seen_o  <= 0;
    end else begin
      if (rsp_valid_i) begin
        if (rsp_pending_q.size() == 0) begin
          $display("%0t: result beat with no request waiting: actual %p", $time, rsp_i);
          mismatch_total++;
        end else begin
          want = rsp_pending_q.pop_front();
          checked_total++;
          if (rsp_i.add_accepted !== want.add_accepted)
            report_field("add_accepted", want.add_accepted, rsp_i.add_accepted);
          if (rsp_i.freed_count !== want.freed_count)
            report_field("freed_count", want.freed_count, rsp_i.freed_count);
          if (rsp_i.occupancy !== want.occupancy)
            report_field("occupancy", want.occupancy, rsp_i.occupancy);
          if (rsp_i.window_full !== want.window_full)
            report_field("window_full", want.window_full, rsp_i.window_full);
        end
      end

      // A size write empties the window.
      if (cfg_we_i) begin
        size_reg   = cfg_wdata_i;
        head_slot  = 0;
        live_count = 0;
      end

      if (start_i && !busy_i) begin
        want = window_apply(req_i);
        if (req_i.req_type == REQ_ADD && !want.add_accepted) refused_total++;
        if (want.window_full) full_total++;
        rsp_pending_q.push_back(want);
      end

      pending_o    <= rsp_pending_q.size();
      mismatches_o <= mismatch_total;
      checked_o    <= checked_total;
      refused_o    <= refused_total;
      full_seen_o  <= full_total;
    end
  end

endmodule

/* bench/tb_inflight_index_window.sv */
// Drives requests and size writes into the index window and gives the verdict;
// the checker beside the block does all prediction and comparison.
module tb_inflight_index_window;

  import iiw_pkg::*;

  localparam logic [1:0]       REQ_UNUSED  = 2'd3;
  localparam logic [IDX_W-1:0] INDEX_MAX   = '1;
  localparam int               STALL_LIMIT = 3000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  req_t              req;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              rsp_valid;
  rsp_t              rsp;

  int                pending;
  int                mismatches;
  int                checked;
  int                refused;
  int                full_seen;

  // Stimulus state.
  int                idle_pct;
  int                stall_cycles;
  int                size_writes;
  logic [IDX_W-1:0]  next_index;
  logic [IDX_W-1:0]  last_added;

  inflight_index_window u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (rsp_valid),
    .rsp_o          (rsp)
  );

  inflight_index_window_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .rsp_valid_i  (rsp_valid),
    .rsp_i        (rsp),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .checked_o    (checked),
    .refused_o    (refused),
    .full_seen_o  (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Ends the run when neither a request nor a result beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || rsp_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("tb_inflight_index_window: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [IDX_W-1:0] rand_index();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[IDX_W-1:0];
  endfunction

  // Presents one request beat, after a random gap, and waits until it is taken.
  // Start stays high afterwards; the caller sends again or lowers it in the same step.
  task automatic send(input logic [1:0] kind, input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    req.req_type  <= kind;
    req.log_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes the window size; only called with the block idle.
  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_writes++;
  endtask

  // One random phase: mostly well-ordered adds and frees that land inside the
  // window, with unordered indexes and unused codes mixed in. A fill phase only
  // releases the oldest entry so that the window reaches full and refuses adds.
  task automatic run_phase(input logic [SIZE_W-1:0] size, input int count,
                           input int add_pct, input bit fill, input int pct);
    int               sel;
    logic [IDX_W-1:0] bound;
    logic [IDX_W-1:0] offset;
    drain();
    write_size(size);
    idle_pct   = pct;
    next_index = ($urandom_range(1) == 0) ? rand_index() : IDX_W'($urandom_range(1000));
    last_added = next_index;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(49) == 0) drain();
      sel = $urandom_range(99);
      if (sel < add_pct) begin
        if ($urandom_range(9) == 0) begin
          last_added = rand_index();
        end else begin
          next_index = next_index + IDX_W'($urandom_range(3));
          last_added = next_index;
        end
        send(REQ_ADD, last_added);
      end else if (fill) begin
        send(($urandom_range(3) == 0) ? REQ_UNUSED : REQ_FREE_FIRST, rand_index());
      end else begin
        sel = $urandom_range(19);
        if (sel < 10) begin
          case ($urandom_range(9))
            0: bound = '0;
            1: bound = INDEX_MAX;
            2: bound = rand_index();
            default: begin
              offset = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(600))
                                                : IDX_W'($urandom_range(12));
              bound = next_index - offset;
            end
          endcase
          send(REQ_FREE_LE, bound);
        end else if (sel < 17) begin
          send(REQ_FREE_FIRST, rand_index());
        end else begin
          send(REQ_UNUSED, rand_index());
        end
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    req         <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    idle_pct     = 0;
    size_writes  = 0;
    next_index   = '0;
    last_added   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset size: empty window, ordering and bounds.
    send(REQ_FREE_LE, '0);
    send(REQ_FREE_FIRST, INDEX_MAX);
    send(REQ_UNUSED, INDEX_MAX);
    send(REQ_ADD, 63'd10);
    send(REQ_ADD, 63'd20);
    send(REQ_ADD, 63'd30);
    send(REQ_FREE_LE, 63'd5);
    send(REQ_FREE_LE, 63'd20);
    send(REQ_FREE_FIRST, '0);
    send(REQ_ADD, INDEX_MAX);
    send(REQ_ADD, '0);
    send(REQ_ADD, 63'd1);
    send(REQ_FREE_LE, INDEX_MAX - 1);
    send(REQ_FREE_LE, INDEX_MAX);

    // Size zero behaves as a single slot.
    drain();
    write_size('0);
    send(REQ_ADD, 63'd7);
    send(REQ_ADD, 63'd8);
    send(REQ_FREE_LE, 63'd7);
    send(REQ_FREE_FIRST, '0);

    // Two slots: refusal when full, then an add that wraps around the ring.
    drain();
    write_size(9'd2);
    send(REQ_ADD, 63'd3);
    send(REQ_ADD, 63'd4);
    send(REQ_ADD, 63'd5);
    send(REQ_FREE_FIRST, '0);
    send(REQ_ADD, 63'd6);
    send(REQ_FREE_LE, INDEX_MAX);

    // Random phases over small, clamped and full-capacity sizes.
    run_phase(9'd1,   60,  50, 1'b0, 0);
    run_phase(9'd0,   60,  50, 1'b0, 55);
    run_phase(9'd2,   60,  55, 1'b0, 36);
    run_phase(9'd3,   60,  55, 1'b0, 0);
    run_phase(9'd5,   80,  60, 1'b0, 55);
    run_phase(9'd16,  120, 60, 1'b0, 36);
    run_phase(9'd511, 300, 95, 1'b1, 0);
    run_phase(9'd256, 120, 60, 1'b0, 55);
    run_phase(9'd255, 100, 70, 1'b0, 36);
    run_phase(9'd257, 80,  55, 1'b0, 0);

    drain();
    repeat (8) @(posedge clk);

    $display("Checked %0d result beats across %0d window size writes.", checked, size_writes);
    $display("Adds refused on a full window: %0d; results reporting full: %0d.",
             refused, full_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_inflight_index_window: done, clean");
    end else begin
      $display("tb_inflight_index_window: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/iiw_pkg.sv
rtl/iiw_ram.sv
rtl/inflight_index_window.sv
bench/inflight_index_window_checker.sv
bench/tb_inflight_index_window.sv
